[rtl/olist_pkg.sv]
package olist_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned STAT_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_SEARCH    = 3'd6
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_INVALID = 3'd2,
    ST_RANGE   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t status;
    logic    found;
  } olist_res_t;

endpackage

[rtl/ordered_list_engine_core.sv]
// Ordered list of signed 32-bit values held as a ring in one CAPACITY-entry
// memory with a head pointer and a count. Each input beat carries one command
// and yields one result beat (status, found flag, count after the command).
// One command is in flight at a time; a new beat is taken while the previous
// result still waits in the output register. Inserts and deletes at either end
// (a positioned insert at index n included) and rejected commands go straight
// to the result state. Insert at index k below n of a list of n entries moves
// the n-k entries from k on back by one, last first, then writes the value;
// delete at an interior index k pulls the n-k-1 entries after it forward; a
// search compares from the front until a match or the last entry. Each moved
// or compared entry needs a read and a write/compare step on the one port pair.
module ordered_list_engine_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [olist_pkg::OP_W-1:0]            in_opcode,
  input  logic signed [olist_pkg::DATA_W-1:0]   in_item_value,
  input  logic [olist_pkg::POS_W-1:0]           in_position,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [olist_pkg::STAT_W-1:0]          out_status,
  output logic                                  out_found,
  output logic [$clog2(CAPACITY+1)-1:0]         out_item_count
);

  import olist_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  olist_res_t        res;
  logic [CW-1:0]     res_count;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic              out_found_r;
  logic [CW-1:0]     out_count_r;

  olist_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_item_value (in_item_value),
    .in_position   (in_position),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .res_count     (res_count)
  );

  olist_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (DATA_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Load a new result once the output slot is free or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r <= res.status;
      out_found_r  <= res.found;
      out_count_r  <= res_count;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found      = out_found_r;
  assign out_item_count = out_count_r;

endmodule

[rtl/olist_mem.sv]
module olist_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/olist_ctrl.sv]
module olist_ctrl #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned AW       = 4,
  parameter int unsigned CW       = 5
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [olist_pkg::OP_W-1:0]            in_opcode,
  input  logic signed [olist_pkg::DATA_W-1:0]   in_item_value,
  input  logic [olist_pkg::POS_W-1:0]           in_position,
  output logic                                  mem_we,
  output logic [AW-1:0]                         mem_waddr,
  output logic [olist_pkg::DATA_W-1:0]          mem_wdata,
  output logic [AW-1:0]                         mem_raddr,
  input  logic [olist_pkg::DATA_W-1:0]          mem_rdata,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output olist_pkg::olist_res_t                 res,
  output logic [CW-1:0]                         res_count
);

  import olist_pkg::*;

  localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [AW:0] CAP_W = (AW + 1)'(CAPACITY);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       stop_r, stop_nxt;
  status_t             status_r, status_nxt;
  logic                found_r, found_nxt;

  op_t                 in_op;
  logic [CMPW-1:0]     pos_ext;
  logic [CMPW-1:0]     cnt_ext;
  logic [CW-1:0]       k_idx;
  logic                full;
  logic                empty;
  logic [AW-1:0]       head_dec;
  logic [AW-1:0]       head_inc;

  // Logical list index to physical slot, wrapping around the ring.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] l);
    logic [AW:0] s;
    begin
      s = {1'b0, hd} + {1'b0, l[AW-1:0]};
      if (s >= CAP_W) begin
        s = s - CAP_W;
      end
      return s[AW-1:0];
    end
  endfunction

  assign in_op    = op_t'(in_opcode);
  assign pos_ext  = CMPW'(in_position);
  assign cnt_ext  = CMPW'(count_r);
  assign k_idx    = CW'(pos_ext - CMPW'(1));
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign head_dec = (head_r == '0) ? LAST_SLOT : head_r - AW'(1);
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    stop_r   <= stop_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    stop_nxt   = stop_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = val_r;
    mem_raddr  = '0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt     = in_op;
          val_nxt    = in_item_value;
          status_nxt = ST_OK;
          found_nxt  = 1'b0;
          state_nxt  = S_DONE;
          unique case (in_op)
            OP_INS_FRONT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                head_nxt  = head_dec;
                mem_we    = 1'b1;
                mem_waddr = head_dec;
                mem_wdata = in_item_value;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_INS_BACK: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_r, count_r);
                mem_wdata = in_item_value;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_INS_AT: begin
              priority if (in_position == '0) begin
                status_nxt = ST_INVALID;
              end else if (pos_ext > cnt_ext + CMPW'(1)) begin
                status_nxt = ST_RANGE;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else if (k_idx == count_r) begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_r, count_r);
                mem_wdata = in_item_value;
                count_nxt = count_r + CW'(1);
              end else begin
                // shift the tail back by one, last entry first
                idx_nxt   = count_r - CW'(1);
                stop_nxt  = k_idx;
                state_nxt = S_RD;
              end
            end
            OP_DEL_FRONT: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                head_nxt  = head_inc;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_DEL_BACK: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            OP_DEL_AT: begin
              priority if (empty) begin
                status_nxt = ST_EMPTY;
              end else if (in_position == '0) begin
                status_nxt = ST_INVALID;
              end else if (pos_ext > cnt_ext) begin
                status_nxt = ST_RANGE;
              end else if (k_idx == '0) begin
                head_nxt  = head_inc;
                count_nxt = count_r - CW'(1);
              end else if (k_idx == count_r - CW'(1)) begin
                count_nxt = count_r - CW'(1);
              end else begin
                // pull the tail forward by one, first entry first
                idx_nxt   = k_idx;
                stop_nxt  = count_r - CW'(2);
                state_nxt = S_RD;
              end
            end
            OP_SEARCH: begin
              if (!empty) begin
                idx_nxt   = '0;
                stop_nxt  = count_r - CW'(1);
                state_nxt = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RD: begin
        if (op_r == OP_DEL_AT) begin
          mem_raddr = phys(head_r, idx_r + CW'(1));
        end else begin
          mem_raddr = phys(head_r, idx_r);
        end
        state_nxt = S_WR;
      end

      S_WR: begin
        if (op_r == OP_SEARCH) begin
          priority if (mem_rdata == val_r) begin
            found_nxt = 1'b1;
            state_nxt = S_DONE;
          end else if (idx_r == stop_r) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_RD;
          end
        end else begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          if (op_r == OP_INS_AT) begin
            mem_waddr = phys(head_r, idx_r + CW'(1));
          end else begin
            mem_waddr = phys(head_r, idx_r);
          end
          if (idx_r == stop_r) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = (op_r == OP_INS_AT) ? idx_r - CW'(1) : idx_r + CW'(1);
            state_nxt = S_RD;
          end
        end
      end

      S_FIN: begin
        if (op_r == OP_INS_AT) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head_r, idx_r);
          mem_wdata = val_r;
          count_nxt = count_r + CW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status = status_r;
  assign res.found  = found_r;
  assign res_count  = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) ||
    (count_r == $past(count_r) - CW'(1)))
    else $error("entry count moved by more than one");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> !mem_we)
    else $error("store written during a read cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("controller idle right after accepting a beat");

endmodule
